// ===== rtl/core/im2col_pkg.sv =====
// ----------------------------------------------------------------------------
// im2col_pkg: shared types and constants of the NHWC im2col address generator
// Register layout, register indexes and the request and descriptor beats.
// ----------------------------------------------------------------------------
package im2col_pkg;

   // Signed width of an input coordinate before the bounds check.
   localparam int IH_W       = 18;
   localparam int SRC_W      = 44;
   localparam int COL_W      = 18;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 13;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IN_HEIGHT         = 4'd0,
      CSR_IN_WIDTH          = 4'd1,
      CSR_IN_CHANNELS       = 4'd2,
      CSR_KERNEL_HEIGHT     = 4'd3,
      CSR_KERNEL_WIDTH      = 4'd4,
      CSR_STRIDE_VERTICAL   = 4'd5,
      CSR_STRIDE_HORIZONTAL = 4'd6,
      CSR_PADDING           = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [12:0] in_height;
      logic [12:0] in_width;
      logic [12:0] in_channels;
      logic [3:0]  kernel_height;
      logic [3:0]  kernel_width;
      logic [3:0]  stride_vertical;
      logic [3:0]  stride_horizontal;
      logic [7:0]  padding;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      in_height:         13'd1,
      in_width:          13'd1,
      in_channels:       13'd1,
      kernel_height:     4'd1,
      kernel_width:      4'd1,
      stride_vertical:   4'd1,
      stride_horizontal: 4'd1,
      padding:           8'd0
   };

   typedef struct packed {
      logic [7:0]  batch_index;
      logic [11:0] out_row;
      logic [11:0] out_col;
   } req_type;

   typedef struct packed {
      logic [SRC_W-1:0] src_offset;
      logic             zero_fill;
      logic [COL_W-1:0] col_offset;
      logic             last;
   } rsp_type;

endpackage

// ===== rtl/core/im2col_nhwc_address_generator.sv =====
// ----------------------------------------------------------------------------
// im2col_nhwc_address_generator: NHWC im2col copy-descriptor generator
// Path: an accepted beat passes the sequencer register and stages A to E.
// Throughput: one descriptor per cycle while rsp_stall is low.
// Reset (synchronous, active high) empties the pipe, restores the registers.
// ----------------------------------------------------------------------------
module im2col_nhwc_address_generator
   import im2col_pkg::*;
#(
   parameter int MAX_KERNEL = 8,
   parameter int MAX_DIM    = 4096
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // The rate is set by the position sequencer, which hands one kernel
   // position per cycle to the pipe while pos_ready is high. It takes the next
   // request beat in the same cycle that its last position leaves, so pixels
   // follow without gaps. A kernel with zero rows or columns consumes its beat.
   //
   // Pipe: sequencer register, A (coordinates), B (bounds, row index and
   // column offset), C (pixel index), D (split product with the channel
   // count), E (sum and descriptor register). Each stage loads when it is
   // empty or when the stage after it moves, so bubbles close up and a
   // stalled descriptor never blocks the stages behind it from filling.

   localparam int KN_W = $clog2(MAX_KERNEL + 1);
   localparam int KC_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int DW   = $clog2(MAX_DIM + 1);
   localparam int RW   = 8 + DW;

   cfg_type          cfg_ff, cfg_in;
   logic [KN_W-1:0]  kh_lim, kw_lim;
   logic [DW-1:0]    h_sat, w_sat, c_sat;

   logic             pos_valid, pos_ready, pos_last;
   req_type          pos_item;
   logic [KC_W-1:0]  pos_kh, pos_kw;

   logic             geo_valid, geo_ready, geo_ok, geo_last;
   logic [RW-1:0]    geo_row_index;
   logic [DW-1:0]    geo_iw;
   logic [COL_W-1:0] geo_col_offset;

   // Configuration writes are always taken; an index past the list is dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IN_HEIGHT: begin
               cfg_in.in_height = csr_data;
            end
            CSR_IN_WIDTH: begin
               cfg_in.in_width = csr_data;
            end
            CSR_IN_CHANNELS: begin
               cfg_in.in_channels = csr_data;
            end
            CSR_KERNEL_HEIGHT: begin
               cfg_in.kernel_height = csr_data[3:0];
            end
            CSR_KERNEL_WIDTH: begin
               cfg_in.kernel_width = csr_data[3:0];
            end
            CSR_STRIDE_VERTICAL: begin
               cfg_in.stride_vertical = csr_data[3:0];
            end
            CSR_STRIDE_HORIZONTAL: begin
               cfg_in.stride_horizontal = csr_data[3:0];
            end
            CSR_PADDING: begin
               cfg_in.padding = csr_data[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Kernel sizes clamp at MAX_KERNEL and map sizes at MAX_DIM. A zero size is kept:
   // a zero map height or width turns every position into padding, a zero kernel size gives none.
   always_comb begin
      kh_lim = (cfg_ff.kernel_height > MAX_KERNEL) ? KN_W'(MAX_KERNEL)
                                                   : KN_W'(cfg_ff.kernel_height);
      kw_lim = (cfg_ff.kernel_width > MAX_KERNEL) ? KN_W'(MAX_KERNEL)
                                                  : KN_W'(cfg_ff.kernel_width);
      h_sat  = (cfg_ff.in_height > MAX_DIM) ? DW'(MAX_DIM) : DW'(cfg_ff.in_height);
      w_sat  = (cfg_ff.in_width > MAX_DIM) ? DW'(MAX_DIM) : DW'(cfg_ff.in_width);
      c_sat  = (cfg_ff.in_channels > MAX_DIM) ? DW'(MAX_DIM) : DW'(cfg_ff.in_channels);
   end

   im2col_seq #(
      .MAX_KERNEL (MAX_KERNEL)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .kh_lim    (kh_lim),
      .kw_lim    (kw_lim),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .pos_valid (pos_valid),
      .pos_ready (pos_ready),
      .pos_item  (pos_item),
      .pos_kh    (pos_kh),
      .pos_kw    (pos_kw),
      .pos_last  (pos_last)
   );

   im2col_geom #(
      .MAX_KERNEL (MAX_KERNEL),
      .MAX_DIM    (MAX_DIM)
   ) u_geom (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .kw_lim         (kw_lim),
      .h_sat          (h_sat),
      .w_sat          (w_sat),
      .c_sat          (c_sat),
      .pos_valid      (pos_valid),
      .pos_ready      (pos_ready),
      .pos_item       (pos_item),
      .pos_kh         (pos_kh),
      .pos_kw         (pos_kw),
      .pos_last       (pos_last),
      .geo_valid      (geo_valid),
      .geo_ready      (geo_ready),
      .geo_ok         (geo_ok),
      .geo_row_index  (geo_row_index),
      .geo_iw         (geo_iw),
      .geo_col_offset (geo_col_offset),
      .geo_last       (geo_last)
   );

   // The descriptor beat leaves straight from the stage E register.
   im2col_offs #(
      .MAX_DIM (MAX_DIM)
   ) u_offs (
      .clock          (clock),
      .reset          (reset),
      .w_sat          (w_sat),
      .c_sat          (c_sat),
      .geo_valid      (geo_valid),
      .geo_ready      (geo_ready),
      .geo_ok         (geo_ok),
      .geo_row_index  (geo_row_index),
      .geo_iw         (geo_iw),
      .geo_col_offset (geo_col_offset),
      .geo_last       (geo_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data)
   );

endmodule

// ===== rtl/core/im2col_seq.sv =====
// ----------------------------------------------------------------------------
// im2col_seq: kernel position sequencer
// Holds one request beat and walks its kernel positions, one per cycle while pos_ready is high.
// ----------------------------------------------------------------------------
module im2col_seq
   import im2col_pkg::*;
#(
   parameter int  MAX_KERNEL = 8,
   localparam int KN_W = $clog2(MAX_KERNEL + 1),
   localparam int KC_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic [KN_W-1:0] kh_lim,
   input  logic [KN_W-1:0] kw_lim,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_type         req_data,
   output logic            pos_valid,
   input  logic            pos_ready,
   output req_type         pos_item,
   output logic [KC_W-1:0] pos_kh,
   output logic [KC_W-1:0] pos_kw,
   output logic            pos_last
);

   logic            busy_ff, busy_in;
   req_type         item_ff, item_in;
   logic [KC_W-1:0] kh_ff, kh_in;
   logic [KC_W-1:0] kw_ff, kw_in;
   logic            kh_end, kw_end, take;

   assign kh_end    = (KN_W'(kh_ff) + KN_W'(1)) == kh_lim;
   assign kw_end    = (KN_W'(kw_ff) + KN_W'(1)) == kw_lim;
   assign req_stall = busy_ff && !(kh_end && kw_end && pos_ready);
   assign take      = req_valid && !req_stall;

   assign pos_valid = busy_ff;
   assign pos_item  = item_ff;
   assign pos_kh    = kh_ff;
   assign pos_kw    = kw_ff;
   assign pos_last  = kh_end && kw_end;

   always_comb begin
      busy_in = busy_ff;
      item_in = item_ff;
      kh_in   = kh_ff;
      kw_in   = kw_ff;
      if (busy_ff && pos_ready) begin
         if (kw_end) begin
            kw_in = '0;
            kh_in = KC_W'(kh_ff + 1'b1);
            if (kh_end) begin
               busy_in = 1'b0;
            end
         end else begin
            kw_in = KC_W'(kw_ff + 1'b1);
         end
      end
      // A kernel with zero rows or columns swallows the beat without output.
      if (take) begin
         item_in = req_data;
         kh_in   = '0;
         kw_in   = '0;
         busy_in = (kh_lim != '0) && (kw_lim != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      item_ff <= item_in;
      kh_ff   <= kh_in;
      kw_ff   <= kw_in;
   end

endmodule

// ===== rtl/core/im2col_geom.sv =====
// ----------------------------------------------------------------------------
// im2col_geom: input coordinate and bounds stages
// Stage A forms the input row and column; stage B checks the bounds and
// forms the image row index and the patch column offset.
// ----------------------------------------------------------------------------
module im2col_geom
   import im2col_pkg::*;
#(
   parameter int  MAX_KERNEL = 8,
   parameter int  MAX_DIM    = 4096,
   localparam int KN_W  = $clog2(MAX_KERNEL + 1),
   localparam int KC_W  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1,
   localparam int DW    = $clog2(MAX_DIM + 1),
   localparam int RW    = 8 + DW
)
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic [KN_W-1:0] kw_lim,
   input  logic [DW-1:0]   h_sat,
   input  logic [DW-1:0]   w_sat,
   input  logic [DW-1:0]   c_sat,
   input  logic            pos_valid,
   output logic            pos_ready,
   input  req_type         pos_item,
   input  logic [KC_W-1:0] pos_kh,
   input  logic [KC_W-1:0] pos_kw,
   input  logic            pos_last,
   output logic            geo_valid,
   input  logic            geo_ready,
   output logic            geo_ok,
   output logic [RW-1:0]   geo_row_index,
   output logic [DW-1:0]   geo_iw,
   output logic [COL_W-1:0] geo_col_offset,
   output logic            geo_last
);

   localparam int IDX_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL * MAX_KERNEL) : 1;

   logic                    en_a, en_b;
   logic                    a_valid_ff;
   logic [7:0]              a_batch_ff, a_batch_in;
   logic signed [IH_W-1:0]  a_ih_ff, a_ih_in;
   logic signed [IH_W-1:0]  a_iw_ff, a_iw_in;
   logic [IDX_W-1:0]        a_idx_ff, a_idx_in;
   logic                    a_last_ff;

   logic                    b_valid_ff;
   logic                    b_ok_ff, b_ok_in;
   logic [RW-1:0]           b_row_ff, b_row_in;
   logic [DW-1:0]           b_iw_ff;
   logic [COL_W-1:0]        b_col_ff, b_col_in;
   logic                    b_last_ff;
   logic                    row_ok, col_ok;

   assign en_b      = !b_valid_ff || geo_ready;
   assign en_a      = !a_valid_ff || en_b;
   assign pos_ready = en_a;

   // Stage A: window origin plus kernel position, padding removed, and the kernel index.
   always_comb begin
      a_batch_in = pos_item.batch_index;
      a_ih_in    = IH_W'(pos_item.out_row * cfg.stride_vertical)
                   - IH_W'(cfg.padding[7:4]) + IH_W'(pos_kh);
      a_iw_in    = IH_W'(pos_item.out_col * cfg.stride_horizontal)
                   - IH_W'(cfg.padding[3:0]) + IH_W'(pos_kw);
      a_idx_in   = IDX_W'(pos_kh * kw_lim) + IDX_W'(pos_kw);
   end

   // Stage B: bounds check; coordinates are only used when inside the map.
   assign row_ok = !a_ih_ff[IH_W-1] && (a_ih_ff < $signed(IH_W'(h_sat)));
   assign col_ok = !a_iw_ff[IH_W-1] && (a_iw_ff < $signed(IH_W'(w_sat)));

   always_comb begin
      b_ok_in  = row_ok && col_ok;
      b_row_in = RW'(a_batch_ff * h_sat) + RW'(a_ih_ff[DW-1:0]);
      b_col_in = COL_W'(a_idx_ff * c_sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (en_a) begin
            a_valid_ff <= pos_valid;
         end
         if (en_b) begin
            b_valid_ff <= a_valid_ff;
         end
      end
      if (en_a) begin
         a_batch_ff <= a_batch_in;
         a_ih_ff    <= a_ih_in;
         a_iw_ff    <= a_iw_in;
         a_idx_ff   <= a_idx_in;
         a_last_ff  <= pos_last;
      end
      if (en_b) begin
         b_ok_ff   <= b_ok_in;
         b_row_ff  <= b_row_in;
         b_iw_ff   <= a_iw_ff[DW-1:0];
         b_col_ff  <= b_col_in;
         b_last_ff <= a_last_ff;
      end
   end

   assign geo_valid      = b_valid_ff;
   assign geo_ok         = b_ok_ff;
   assign geo_row_index  = b_row_ff;
   assign geo_iw         = b_iw_ff;
   assign geo_col_offset = b_col_ff;
   assign geo_last       = b_last_ff;

endmodule

// ===== rtl/core/im2col_offs.sv =====
// ----------------------------------------------------------------------------
// im2col_offs: source offset stages
// Stage C forms the pixel index, stage D the two partial products with the
// channel count, stage E sums them into the registered descriptor beat.
// ----------------------------------------------------------------------------
module im2col_offs
   import im2col_pkg::*;
#(
   parameter int  MAX_DIM = 4096,
   localparam int DW = $clog2(MAX_DIM + 1),
   localparam int RW = 8 + DW
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic [DW-1:0]    w_sat,
   input  logic [DW-1:0]    c_sat,
   input  logic             geo_valid,
   output logic             geo_ready,
   input  logic             geo_ok,
   input  logic [RW-1:0]    geo_row_index,
   input  logic [DW-1:0]    geo_iw,
   input  logic [COL_W-1:0] geo_col_offset,
   input  logic             geo_last,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   localparam int TW    = 8 + 2 * DW;
   localparam int LO_W  = TW / 2;
   localparam int HI_W  = TW - LO_W;
   localparam int PL_W  = LO_W + DW;
   localparam int PH_W  = HI_W + DW;
   localparam int SUM_W = (TW + DW > SRC_W) ? TW + DW : SRC_W;

   logic             en_c, en_d, en_e;
   logic             c_valid_ff, c_ok_ff, c_last_ff;
   logic [TW-1:0]    c_t_ff, c_t_in;
   logic [COL_W-1:0] c_col_ff;
   logic             d_valid_ff, d_ok_ff, d_last_ff;
   logic [PL_W-1:0]  d_plo_ff, d_plo_in;
   logic [PH_W-1:0]  d_phi_ff, d_phi_in;
   logic [COL_W-1:0] d_col_ff;
   logic             e_valid_ff;
   rsp_type          e_data_ff, e_data_in;
   logic [SUM_W-1:0] sum;

   assign en_e      = !e_valid_ff || !rsp_stall;
   assign en_d      = !d_valid_ff || en_e;
   assign en_c      = !c_valid_ff || en_d;
   assign geo_ready = en_c;

   assign c_t_in   = TW'(geo_row_index * w_sat) + TW'(geo_iw);
   assign d_plo_in = PL_W'(c_t_ff[LO_W-1:0] * c_sat);
   assign d_phi_in = PH_W'(c_t_ff[TW-1:LO_W] * c_sat);
   assign sum      = SUM_W'(d_plo_ff) + (SUM_W'(d_phi_ff) << LO_W);

   always_comb begin
      e_data_in.src_offset = d_ok_ff ? sum[SRC_W-1:0] : '0;
      e_data_in.zero_fill  = !d_ok_ff;
      e_data_in.col_offset = d_col_ff;
      e_data_in.last       = d_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         if (en_c) begin
            c_valid_ff <= geo_valid;
         end
         if (en_d) begin
            d_valid_ff <= c_valid_ff;
         end
         if (en_e) begin
            e_valid_ff <= d_valid_ff;
         end
      end
      if (en_c) begin
         c_ok_ff   <= geo_ok;
         c_t_ff    <= c_t_in;
         c_col_ff  <= geo_col_offset;
         c_last_ff <= geo_last;
      end
      if (en_d) begin
         d_ok_ff   <= c_ok_ff;
         d_plo_ff  <= d_plo_in;
         d_phi_ff  <= d_phi_in;
         d_col_ff  <= c_col_ff;
         d_last_ff <= c_last_ff;
      end
      if (en_e) begin
         e_data_ff <= e_data_in;
      end
   end

   assign rsp_valid = e_valid_ff;
   assign rsp_data  = e_data_ff;

endmodule
